>>> rtl/line_pair_intersection_macros.svh
// -----------------------------------------------------------------------------
// Line pair intersection assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// -----------------------------------------------------------------------------
`ifndef LINE_PAIR_INTERSECTION_MACROS_SVH
`define LINE_PAIR_INTERSECTION_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LPI_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define LPI_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/lpi_pkg.sv
// -----------------------------------------------------------------------------
// Line pair intersection package
// Fixed output format, register reset value and status bit positions.
// -----------------------------------------------------------------------------
`default_nettype none

package lpi_pkg;

   // Width of one output coordinate.
   localparam int OUT_BITS = 20;

   // Width and reset value of the acceptance ratio register.
   localparam int RATIO_W = 4;
   localparam logic [RATIO_W-1:0] RATIO_RESET = 4'd3;

   // Bit positions in the result tuser.
   localparam int USER_HIT  = 0;
   localparam int USER_CLIP = 1;
   localparam int USER_W    = 2;

   typedef logic [RATIO_W-1:0] ratio_type;

endpackage

`default_nettype wire

>>> rtl/line_pair_intersection.sv
// -----------------------------------------------------------------------------
// Line pair intersection
// Intersection point of two lines, each given by two pixel endpoints.
// -----------------------------------------------------------------------------
// Each request beat carries two lines, A through (x1,y1),(x2,y2) and B through
// (x3,y3),(x4,y4). The block forms the cross term P and the dot term Q of the
// two direction vectors and accepts the pair when P is nonzero and |Q| is
// below parallel_ratio times |P|, so near-parallel pairs are rejected. For an
// accepted pair the intersection comes from the determinant formula, exact in
// integers, as signed fixed point with FRAC_BITS fraction bits, truncated
// toward zero and saturated to 20 bits with a clipped flag. A rejected pair
// returns hit low and the point (-1.0, -1.0). Every request beat yields exactly
// one response beat, in order. The pipeline takes one beat per clock unless
// the response stalls. It has seven stages of multiply, add, absolute value
// and overflow check, the 20 restoring divider stages (one quotient bit per
// stage) and the output register. Each stage advances whenever it is empty
// or the stage after it moves, so bubbles close up while the response waits.
// The ratio register is to be written through the csr channel only while no
// beat is in flight, which the block does not enforce; csr_ready is always high.
// -----------------------------------------------------------------------------
`default_nettype none

module line_pair_intersection #(
   parameter int COORD_BITS = 12,
   parameter int FRAC_BITS  = 4
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // Configuration: parallel_ratio.
   input  wire logic                                  csr_valid,
   output      logic                                  csr_ready,
   input  wire lpi_pkg::ratio_type                    csr_data,
   // Request: line_a_x1, line_a_y1, line_a_x2, line_a_y2,
   //          line_b_x1, line_b_y1, line_b_x2, line_b_y2, zero padding.
   input  wire logic                                  req_tvalid,
   output      logic                                  req_tready,
   input  wire logic [((8*COORD_BITS+7)/8)*8-1:0]     req_tdata,
   // Response tdata: cross_x, cross_y.
   output      logic                                  rsp_tvalid,
   input  wire logic                                  rsp_tready,
   output      logic [2*lpi_pkg::OUT_BITS-1:0]        rsp_tdata,
   // Response tuser: hit, clipped.
   output      logic [lpi_pkg::USER_W-1:0]            rsp_tuser
);

   import lpi_pkg::*;

   // Operand widths, all exact for the coordinate range.
   localparam int CB  = COORD_BITS;
   localparam int DB  = CB + 1;          // endpoint difference, signed
   localparam int MB  = 2 * DB;          // product of two differences
   localparam int PB  = 2 * CB + 3;      // P and Q, signed
   localparam int UB  = 2 * CB;          // coordinate product, unsigned
   localparam int CAB = 2 * CB + 1;      // cA and cB, signed
   localparam int NPB = CAB + DB;        // numerator partial product
   localparam int NB  = NPB + 1;         // numerator, signed
   localparam int NS  = NB + FRAC_BITS;  // scaled numerator
   localparam int QB  = OUT_BITS;        // quotient bits
   localparam int DW  = ((NS > PB + QB) ? NS : PB + QB) + 1;  // divider width
   localparam int PRE = 7;               // stages before the divider
   localparam int NST = PRE + QB + 1;    // total stages

   localparam logic [QB-1:0] NOHIT   = QB'(-(1 << FRAC_BITS));
   localparam logic [QB-1:0] POS_MAX = {1'b0, {(QB-1){1'b1}}};
   localparam logic [QB-1:0] NEG_MAG = {1'b1, {(QB-1){1'b0}}};

   // ---------------------------------------------------------------------------
   // Configuration register.
   // ---------------------------------------------------------------------------
   ratio_type ratio_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ratio_ff <= RATIO_RESET;
      end else if (csr_valid) begin
         ratio_ff <= csr_data;
      end
   end

   // ---------------------------------------------------------------------------
   // Stage valids and enables. A stage loads when it is empty or when its
   // contents move on, so a stall at the output holds nothing that can move.
   // ---------------------------------------------------------------------------
   logic [NST:1] vld_ff;
   logic [NST:1] vld_in;
   logic [NST:1] en;

   assign en[NST] = !vld_ff[NST] || rsp_tready;
   for (genvar i = 1; i < NST; i++) begin : g_en
      assign en[i] = !vld_ff[i] || en[i+1];
   end

   assign req_tready = en[1];
   assign vld_in[1]  = req_tvalid;
   for (genvar i = 2; i <= NST; i++) begin : g_vin
      assign vld_in[i] = vld_ff[i-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int i = 1; i <= NST; i++) begin
            if (en[i]) begin
               vld_ff[i] <= vld_in[i];
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Stage 1: unpack the beat and form the direction vectors.
   // ---------------------------------------------------------------------------
   logic [CB-1:0] ax1, ay1, ax2, ay2, bx1, by1, bx2, by2;

   assign ax1 = req_tdata[0*CB +: CB];
   assign ay1 = req_tdata[1*CB +: CB];
   assign ax2 = req_tdata[2*CB +: CB];
   assign ay2 = req_tdata[3*CB +: CB];
   assign bx1 = req_tdata[4*CB +: CB];
   assign by1 = req_tdata[5*CB +: CB];
   assign bx2 = req_tdata[6*CB +: CB];
   assign by2 = req_tdata[7*CB +: CB];

   logic [CB-1:0]        ax1_ff, ay1_ff, ax2_ff, ay2_ff;
   logic [CB-1:0]        bx1_ff, by1_ff, bx2_ff, by2_ff;
   logic signed [DB-1:0] dax1_ff, day1_ff, dbx1_ff, dby1_ff;

   always_ff @(posedge clock) begin
      if (en[1]) begin
         ax1_ff  <= ax1;
         ay1_ff  <= ay1;
         ax2_ff  <= ax2;
         ay2_ff  <= ay2;
         bx1_ff  <= bx1;
         by1_ff  <= by1;
         bx2_ff  <= bx2;
         by2_ff  <= by2;
         dax1_ff <= $signed({1'b0, ax1}) - $signed({1'b0, ax2});
         day1_ff <= $signed({1'b0, ay1}) - $signed({1'b0, ay2});
         dbx1_ff <= $signed({1'b0, bx1}) - $signed({1'b0, bx2});
         dby1_ff <= $signed({1'b0, by1}) - $signed({1'b0, by2});
      end
   end

   // ---------------------------------------------------------------------------
   // Stage 2: the eight products behind P, Q, cA and cB.
   // ---------------------------------------------------------------------------
   logic signed [MB-1:0] pm1_ff, pm2_ff, qm1_ff, qm2_ff;
   logic [UB-1:0]        ua1_ff, ua2_ff, ub1_ff, ub2_ff;
   logic signed [DB-1:0] dax2_ff, day2_ff, dbx2_ff, dby2_ff;

   always_ff @(posedge clock) begin
      if (en[2]) begin
         pm1_ff  <= MB'(dax1_ff) * MB'(dby1_ff);
         pm2_ff  <= MB'(day1_ff) * MB'(dbx1_ff);
         qm1_ff  <= MB'(dax1_ff) * MB'(dbx1_ff);
         qm2_ff  <= MB'(day1_ff) * MB'(dby1_ff);
         ua1_ff  <= UB'(ax1_ff) * UB'(ay2_ff);
         ua2_ff  <= UB'(ay1_ff) * UB'(ax2_ff);
         ub1_ff  <= UB'(bx1_ff) * UB'(by2_ff);
         ub2_ff  <= UB'(by1_ff) * UB'(bx2_ff);
         dax2_ff <= dax1_ff;
         day2_ff <= day1_ff;
         dbx2_ff <= dbx1_ff;
         dby2_ff <= dby1_ff;
      end
   end

   // ---------------------------------------------------------------------------
   // Stage 3: cross term, dot term and the two line constants.
   // ---------------------------------------------------------------------------
   logic signed [PB-1:0]  p3_ff, q3_ff;
   logic signed [CAB-1:0] ca3_ff, cb3_ff;
   logic signed [DB-1:0]  dax3_ff, day3_ff, dbx3_ff, dby3_ff;

   always_ff @(posedge clock) begin
      if (en[3]) begin
         p3_ff   <= PB'(pm1_ff) - PB'(pm2_ff);
         q3_ff   <= PB'(qm1_ff) + PB'(qm2_ff);
         ca3_ff  <= $signed({1'b0, ua1_ff}) - $signed({1'b0, ua2_ff});
         cb3_ff  <= $signed({1'b0, ub1_ff}) - $signed({1'b0, ub2_ff});
         dax3_ff <= dax2_ff;
         day3_ff <= day2_ff;
         dbx3_ff <= dbx2_ff;
         dby3_ff <= dby2_ff;
      end
   end

   // ---------------------------------------------------------------------------
   // Stage 4: magnitudes of P and Q, numerator partial products.
   // ---------------------------------------------------------------------------
   logic [PB-1:0]         absp4_ff, absq4_ff;
   logic                  signp4_ff, pnz4_ff;
   logic signed [NPB-1:0] nx1_ff, nx2_ff, ny1_ff, ny2_ff;

   always_ff @(posedge clock) begin
      if (en[4]) begin
         absp4_ff  <= p3_ff[PB-1] ? PB'(-p3_ff) : PB'(p3_ff);
         absq4_ff  <= q3_ff[PB-1] ? PB'(-q3_ff) : PB'(q3_ff);
         signp4_ff <= p3_ff[PB-1];
         pnz4_ff   <= (p3_ff != '0);
         nx1_ff    <= NPB'(ca3_ff) * NPB'(dbx3_ff);
         nx2_ff    <= NPB'(cb3_ff) * NPB'(dax3_ff);
         ny1_ff    <= NPB'(ca3_ff) * NPB'(dby3_ff);
         ny2_ff    <= NPB'(cb3_ff) * NPB'(day3_ff);
      end
   end

   // ---------------------------------------------------------------------------
   // Stage 5: acceptance test and scaled numerators.
   // ---------------------------------------------------------------------------
   logic signed [NB-1:0] nx5, ny5;
   logic [PB+3:0]        lim5;

   assign nx5  = NB'(nx1_ff) - NB'(nx2_ff);
   assign ny5  = NB'(ny1_ff) - NB'(ny2_ff);
   assign lim5 = (PB+4)'(ratio_ff) * (PB+4)'(absp4_ff);

   logic signed [NS-1:0] nx5_ff, ny5_ff;
   logic [PB-1:0]        absp5_ff;
   logic                 signp5_ff, hit5_ff;

   always_ff @(posedge clock) begin
      if (en[5]) begin
         nx5_ff    <= NS'(nx5) <<< FRAC_BITS;
         ny5_ff    <= NS'(ny5) <<< FRAC_BITS;
         absp5_ff  <= absp4_ff;
         signp5_ff <= signp4_ff;
         hit5_ff   <= pnz4_ff && ((PB+4)'(absq4_ff) < lim5);
      end
   end

   // ---------------------------------------------------------------------------
   // Stage 6: numerator magnitudes and quotient signs.
   // ---------------------------------------------------------------------------
   logic [NS-1:0] absnx6_ff, absny6_ff;
   logic [PB-1:0] absp6_ff;
   logic          negx6_ff, negy6_ff, hit6_ff;

   always_ff @(posedge clock) begin
      if (en[6]) begin
         absnx6_ff <= nx5_ff[NS-1] ? NS'(-nx5_ff) : NS'(nx5_ff);
         absny6_ff <= ny5_ff[NS-1] ? NS'(-ny5_ff) : NS'(ny5_ff);
         negx6_ff  <= nx5_ff[NS-1] ^ signp5_ff;
         negy6_ff  <= ny5_ff[NS-1] ^ signp5_ff;
         absp6_ff  <= absp5_ff;
         hit6_ff   <= hit5_ff;
      end
   end

   // ---------------------------------------------------------------------------
   // Stage 7: overflow check. A quotient of 2^QB or more saturates for either
   // sign, so the divider only has to produce QB bits.
   // ---------------------------------------------------------------------------
   logic [DW-1:0] rx_ff [0:QB];
   logic [DW-1:0] ry_ff [0:QB];
   logic [QB-1:0] qx_ff [0:QB];
   logic [QB-1:0] qy_ff [0:QB];
   logic [PB-1:0] dp_ff [0:QB];
   logic [QB:0]   negx_ff, negy_ff, ovfx_ff, ovfy_ff, hit_ff;
   logic [DW-1:0] top7;

   assign top7 = DW'(absp6_ff) << QB;

   always_ff @(posedge clock) begin
      if (en[PRE]) begin
         rx_ff[0]   <= DW'(absnx6_ff);
         ry_ff[0]   <= DW'(absny6_ff);
         qx_ff[0]   <= '0;
         qy_ff[0]   <= '0;
         dp_ff[0]   <= absp6_ff;
         negx_ff[0] <= negx6_ff;
         negy_ff[0] <= negy6_ff;
         ovfx_ff[0] <= (DW'(absnx6_ff) >= top7);
         ovfy_ff[0] <= (DW'(absny6_ff) >= top7);
         hit_ff[0]  <= hit6_ff;
      end
   end

   // ---------------------------------------------------------------------------
   // Restoring divider: one quotient bit per stage, most significant first,
   // for x and y side by side over the shared divisor |P|.
   // ---------------------------------------------------------------------------
   for (genvar j = 0; j < QB; j++) begin : g_div
      localparam int SH = QB - 1 - j;
      logic [DW-1:0] dv;
      logic          takex, takey;
      logic [QB-1:0] qx_in, qy_in;

      always_comb begin
         dv    = DW'(dp_ff[j]) << SH;
         takex = (rx_ff[j] >= dv);
         takey = (ry_ff[j] >= dv);
         qx_in = qx_ff[j];
         qy_in = qy_ff[j];
         qx_in[SH] = takex;
         qy_in[SH] = takey;
      end

      always_ff @(posedge clock) begin
         if (en[PRE+1+j]) begin
            rx_ff[j+1]   <= takex ? rx_ff[j] - dv : rx_ff[j];
            ry_ff[j+1]   <= takey ? ry_ff[j] - dv : ry_ff[j];
            qx_ff[j+1]   <= qx_in;
            qy_ff[j+1]   <= qy_in;
            dp_ff[j+1]   <= dp_ff[j];
            negx_ff[j+1] <= negx_ff[j];
            negy_ff[j+1] <= negy_ff[j];
            ovfx_ff[j+1] <= ovfx_ff[j];
            ovfy_ff[j+1] <= ovfy_ff[j];
            hit_ff[j+1]  <= hit_ff[j];
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Output stage: apply the sign, saturate, and substitute the rejected point.
   // The result is {clip, value}.
   // ---------------------------------------------------------------------------
   function automatic logic [QB:0] finish(input logic [QB-1:0] q, input logic neg,
                                          input logic ovf);
      logic [QB:0] r;
      if (neg) begin
         if (ovf || (q > NEG_MAG)) begin
            r = {1'b1, NEG_MAG};
         end else begin
            r = {1'b0, QB'(~q) + QB'(1)};
         end
      end else begin
         if (ovf || (q > POS_MAX)) begin
            r = {1'b1, POS_MAX};
         end else begin
            r = {1'b0, q};
         end
      end
      return r;
   endfunction

   logic [QB:0]   fx, fy;
   logic [QB-1:0] ox_ff, oy_ff;
   logic          ohit_ff, oclip_ff;

   assign fx = finish(qx_ff[QB], negx_ff[QB], ovfx_ff[QB]);
   assign fy = finish(qy_ff[QB], negy_ff[QB], ovfy_ff[QB]);

   always_ff @(posedge clock) begin
      if (en[NST]) begin
         ohit_ff <= hit_ff[QB];
         if (hit_ff[QB]) begin
            ox_ff    <= fx[QB-1:0];
            oy_ff    <= fy[QB-1:0];
            oclip_ff <= fx[QB] || fy[QB];
         end else begin
            ox_ff    <= NOHIT;
            oy_ff    <= NOHIT;
            oclip_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid           = vld_ff[NST];
   assign rsp_tdata            = {oy_ff, ox_ff};
   assign rsp_tuser[USER_HIT]  = ohit_ff;
   assign rsp_tuser[USER_CLIP] = oclip_ff;

   // ---------------------------------------------------------------------------
   // Assertions.
   // ---------------------------------------------------------------------------
`include "line_pair_intersection_macros.svh"

   // A rejected pair carries the fixed point (-1.0, -1.0) and no clip.
   `LPI_ASSERT_IMP(a_nohit_point, clock, reset, rsp_tvalid && !rsp_tuser[USER_HIT], (ox_ff == NOHIT) && (oy_ff == NOHIT) && !rsp_tuser[USER_CLIP], "rejected pair with a computed point")

   // A clipped result has at least one coordinate at a range limit.
   `LPI_ASSERT_IMP(a_clip_limit, clock, reset, rsp_tvalid && rsp_tuser[USER_CLIP], (ox_ff == POS_MAX) || (ox_ff == NEG_MAG) || (oy_ff == POS_MAX) || (oy_ff == NEG_MAG), "clip flag without saturation")

   // An accepted request beat always lands in the first stage.
   `LPI_ASSERT_NXT(a_req_enters, clock, reset, req_tvalid && req_tready, vld_ff[1], "accepted beat lost at entry")

   // A register write takes effect on the next cycle.
   `LPI_ASSERT_NXT(a_csr_write, clock, reset, csr_valid && csr_ready, ratio_ff == $past(csr_data), "ratio register not written")

endmodule

`default_nettype wire

>>> sim/line_pair_intersection_tb.sv
// -----------------------------------------------------------------------------
// Line pair intersection testbench
// Sends line pairs with random idling on both streams, predicts each response
// beat with exact integer arithmetic and compares it field by field, in order.
// -----------------------------------------------------------------------------
`default_nettype none

module line_pair_intersection_tb;

   import lpi_pkg::*;

   localparam int COORD_BITS = 12;
   localparam int FRAC_BITS  = 4;
   localparam int REQ_W      = ((8*COORD_BITS+7)/8)*8;
   localparam int LATENCY    = 28;
   localparam int CYCLE_LIMIT = 400000;
   localparam logic [COORD_BITS-1:0] CMAX = '1;

   typedef logic [COORD_BITS-1:0] coord_type;
   typedef struct packed {
      logic                       hit;
      logic signed [OUT_BITS-1:0] px;
      logic signed [OUT_BITS-1:0] py;
      logic                       clipped;
   } point_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_valid = 1'b0;
   logic csr_ready;
   ratio_type csr_data = '0;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [2*OUT_BITS-1:0] rsp_tdata;
   logic [USER_W-1:0] rsp_tuser;

   ratio_type ratio_now = RATIO_RESET;
   point_type point_queue[$];
   int        fail_count = 0;
   int        cycle_count = 0;
   bit        steady_phase = 1'b0;

   line_pair_intersection #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) dut (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   always #1 clock = ~clock;

   // Saturates to the 20-bit output range and flags the clip.
   function automatic logic signed [OUT_BITS-1:0] clamp_coord(longint v, ref logic clip);
      longint hi;
      longint lo;
      hi = (64'sd1 <<< (OUT_BITS-1)) - 1;
      lo = -hi - 1;
      if (v > hi) begin
         clip = 1'b1;
         return hi[OUT_BITS-1:0];
      end
      if (v < lo) begin
         clip = 1'b1;
         return lo[OUT_BITS-1:0];
      end
      return v[OUT_BITS-1:0];
   endfunction

   // Intersection point of line A (x1,y1)-(x2,y2) and line B (x3,y3)-(x4,y4).
   function automatic point_type intersect_lines(coord_type c[8], ratio_type ratio);
      longint x1, y1, x2, y2, x3, y3, x4, y4;
      longint dax, day, dbx, dby, cross_term, dot_term, ca, cb, nx, ny;
      point_type pt;
      logic clip;
      x1 = c[0]; y1 = c[1]; x2 = c[2]; y2 = c[3];
      x3 = c[4]; y3 = c[5]; x4 = c[6]; y4 = c[7];
      dax = x1 - x2; day = y1 - y2; dbx = x3 - x4; dby = y3 - y4;
      cross_term = dax * dby - day * dbx;
      dot_term   = dax * dbx + day * dby;
      clip = 1'b0;
      pt.hit = (cross_term != 0) && ((dot_term < 0 ? -dot_term : dot_term) <
               longint'(ratio) * (cross_term < 0 ? -cross_term : cross_term));
      if (pt.hit) begin
         ca = x1 * y2 - y1 * x2;
         cb = x3 * y4 - y3 * x4;
         // Division of longint truncates toward zero, as required.
         nx = (ca * dbx - cb * dax) * (64'sd1 <<< FRAC_BITS);
         ny = (ca * dby - cb * day) * (64'sd1 <<< FRAC_BITS);
         pt.px = clamp_coord(nx / cross_term, clip);
         pt.py = clamp_coord(ny / cross_term, clip);
      end else begin
         pt.px = OUT_BITS'(-(1 <<< FRAC_BITS));
         pt.py = OUT_BITS'(-(1 <<< FRAC_BITS));
      end
      pt.clipped = clip;
      return pt;
   endfunction

   function automatic bit idle_now();
      return !steady_phase && ($urandom_range(99) < 28);
   endfunction

   // Sends one line pair and records its expected response beat. The valid
   // stays high after the beat so that the next pair can follow directly.
   task automatic send_pair(coord_type c[8]);
      logic [REQ_W-1:0] beat;
      beat = '0;
      for (int i = 0; i < 8; i++) beat[i*COORD_BITS +: COORD_BITS] = c[i];
      while (idle_now()) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= beat;
      do @(posedge clock); while (!req_tready);
      point_queue.insert(point_queue.size(), intersect_lines(c, ratio_now));
   endtask

   task automatic drain_pipeline();
      req_tvalid <= 1'b0;
      while (point_queue.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_ratio(ratio_type r);
      drain_pipeline();
      csr_valid <= 1'b1;
      csr_data  <= r;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      ratio_now = r;
   endtask

   task automatic send_random_pairs(int n, bit short_lines);
      coord_type c[8];
      for (int k = 0; k < n; k++) begin
         for (int i = 0; i < 8; i++) c[i] = coord_type'($urandom_range(0, CMAX));
         if (short_lines) begin
            // Short segments push the intersection far off and into saturation.
            c[2] = coord_type'(c[0] + $urandom_range(0, 6) - 3);
            c[3] = coord_type'(c[1] + $urandom_range(0, 6) - 3);
         end else if ($urandom_range(9) == 0) begin
            // Parallel or identical direction vectors.
            c[6] = c[4] + (c[2] - c[0]);
            c[7] = c[5] + (c[3] - c[1]);
         end
         send_pair(c);
      end
   endtask

   task automatic test_corner_pairs();
      coord_type c[8];
      // Perpendicular axes crossing in the middle.
      c = '{0, 2048, CMAX, 2048, 2048, 0, 2048, CMAX}; send_pair(c);
      // Degenerate line A: both endpoints equal, cross term zero.
      c = '{5, 5, 5, 5, 0, 0, CMAX, CMAX}; send_pair(c);
      // Exactly parallel lines.
      c = '{0, 0, 100, 100, 0, 10, 100, 110}; send_pair(c);
      // All zero and all full scale.
      c = '{0, 0, 0, 0, 0, 0, 0, 0}; send_pair(c);
      c = '{CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX}; send_pair(c);
      // Extreme corners, diagonals crossing.
      c = '{0, 0, CMAX, CMAX, 0, CMAX, CMAX, 0}; send_pair(c);
      c = '{CMAX, 0, 0, CMAX, 0, 0, CMAX, CMAX}; send_pair(c);
      // Nearly parallel, far-away crossing, rejected at the reset ratio.
      c = '{0, 0, CMAX, 1, 0, 1, CMAX, 3}; send_pair(c);
      c = '{0, CMAX, 1, 0, 2, CMAX, 4, 0}; send_pair(c);
      // Crossing at positive coordinates with a fractional part.
      c = '{0, 1, 3, 2, 1, 0, 2, 3}; send_pair(c);
      c = '{10, 0, 11, 3, 0, 5, 7, 6}; send_pair(c);
   endtask

   task automatic test_ratio_settings();
      ratio_type r;
      write_ratio(4'd15);
      send_random_pairs(60, 1'b0);
      write_ratio(4'd1);
      send_random_pairs(60, 1'b0);
      write_ratio(4'd0);
      send_random_pairs(20, 1'b0);
      for (int k = 0; k < 4; k++) begin
         r = ratio_type'($urandom_range(1, 15));
         write_ratio(r);
         send_random_pairs(150, 1'b0);
      end
      write_ratio(RATIO_RESET);
   endtask

   task automatic test_saturation();
      send_random_pairs(80, 1'b1);
   endtask

   task automatic test_steady_stream();
      // No idling anywhere: back-to-back beats with an always-ready sink.
      steady_phase = 1'b1;
      send_random_pairs(150, 1'b0);
      steady_phase = 1'b0;
      // Hold off until the pipeline is empty, then resume.
      drain_pipeline();
      send_random_pairs(220, 1'b0);
   endtask

   // Response sink with random stalls.
   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= !idle_now();
   end

   // Compares every response beat with the oldest prediction.
   always @(posedge clock) begin
      point_type want;
      logic signed [OUT_BITS-1:0] got_x, got_y;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_x = rsp_tdata[0 +: OUT_BITS];
         got_y = rsp_tdata[OUT_BITS +: OUT_BITS];
         if (point_queue.size() == 0) begin
            $error("response beat with no pending line pair");
            fail_count++;
         end else begin
            want = point_queue.pop_front();
            if (rsp_tuser[USER_HIT] !== want.hit) begin
               $error("hit: expected %0d, got %0d", want.hit, rsp_tuser[USER_HIT]);
               fail_count++;
            end
            if (got_x !== want.px) begin
               $error("cross_x: expected %0d, got %0d", want.px, got_x);
               fail_count++;
            end
            if (got_y !== want.py) begin
               $error("cross_y: expected %0d, got %0d", want.py, got_y);
               fail_count++;
            end
            if (rsp_tuser[USER_CLIP] !== want.clipped) begin
               $error("clipped: expected %0d, got %0d", want.clipped, rsp_tuser[USER_CLIP]);
               fail_count++;
            end
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_corner_pairs();
      test_ratio_settings();
      test_saturation();
      test_steady_stream();
      drain_pipeline();
      repeat (LATENCY + 4) @(posedge clock);
      if (fail_count == 0 && point_queue.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

`default_nettype wire

>>> sim.f
+incdir+rtl
rtl/lpi_pkg.sv
rtl/line_pair_intersection.sv
sim/line_pair_intersection_tb.sv
